// ----- sv/tcrd_pkg.sv -----
// Shared types, constants and tables for the three-channel rank display.
`default_nettype none

package tcrd_pkg;

    // Fixed field widths of the item channels
    localparam int SAMPLE_IN_BITS      = 10;
    localparam int CHAN_BITS           = 5;
    localparam int SEG_BITS            = 7;
    localparam int DIGITS              = 3;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // Configuration port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // Channel register reset values
    localparam logic [CHAN_BITS-1:0] FIRST_CHAN_RST  = 5'd12;
    localparam logic [CHAN_BITS-1:0] SECOND_CHAN_RST = 5'd10;
    localparam logic [CHAN_BITS-1:0] THIRD_CHAN_RST  = 5'd8;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_FIRST_CHAN  = 2'd0,
        REG_SECOND_CHAN = 2'd1,
        REG_THIRD_CHAN  = 2'd2
    } reg_idx_t;

    // Input action codes and result kinds share one encoding
    typedef enum logic {
        KIND_SAMPLE  = 1'b0,
        KIND_DISPLAY = 1'b1
    } kind_t;

    // Ranked channel numbers shown on the display
    typedef enum logic [1:0] {
        RANK_CH1 = 2'd1,
        RANK_CH2 = 2'd2,
        RANK_CH3 = 2'd3
    } rank_ch_t;

    // Slot / digit counter positions
    localparam logic [1:0] POS_0 = 2'd0;
    localparam logic [1:0] POS_1 = 2'd1;
    localparam logic [1:0] POS_2 = 2'd2;

    // Digit enable base pattern and idle value (all digits off, active low)
    localparam logic [DIGITS-1:0] DIGIT_ONE_HOT = 3'h1;
    localparam logic [DIGITS-1:0] DIGITS_OFF    = 3'h7;

    // Seven-segment codes for 0..9, bit0 = segment a
    localparam logic [SEG_BITS-1:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
        7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

endpackage

`default_nettype wire

// ----- sv/tcrd_in_if.sv -----
// Input item channel: conversion results and display ticks.
`default_nettype none

interface tcrd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [tcrd_pkg::SAMPLE_IN_BITS-1:0] sample_value;

    modport source (output valid, output action, output sample_value, input ready);
    modport sink   (input valid, input action, input sample_value, output ready);
endinterface

`default_nettype wire

// ----- sv/tcrd_out_if.sv -----
// Result item channel: next converter channel or driven display digit.
`default_nettype none

interface tcrd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           result_kind;
    logic [tcrd_pkg::CHAN_BITS-1:0] next_channel;
    logic [tcrd_pkg::SEG_BITS-1:0]  segment_pattern;
    logic [tcrd_pkg::DIGITS-1:0]    digit_enable;

    modport source (
        output valid, output result_kind, output next_channel,
        output segment_pattern, output digit_enable, input ready
    );
    modport sink (
        input valid, input result_kind, input next_channel,
        input segment_pattern, input digit_enable, output ready
    );
endinterface

`default_nettype wire

// ----- sv/tcrd_rank.sv -----
// Ranks three stored samples and returns the segment code for one rank position.
`default_nettype none

module tcrd_rank #(
    parameter int SAMPLE_BITS = tcrd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic [SAMPLE_BITS-1:0]          samples [3],
    input  wire logic [1:0]                      position,
    output logic      [tcrd_pkg::SEG_BITS-1:0]   segment_pattern
);

    logic a_ge_b;
    logic a_ge_c;
    logic b_ge_a;
    logic b_ge_c;
    tcrd_pkg::rank_ch_t order [3];
    tcrd_pkg::rank_ch_t shown;

    assign a_ge_b = samples[0] >= samples[1];
    assign a_ge_c = samples[0] >= samples[2];
    assign b_ge_a = samples[1] >= samples[0];
    assign b_ge_c = samples[1] >= samples[2];

    // Ties go to the lower channel number
    always_comb
    begin
        if (a_ge_b && a_ge_c)
        begin
            order[0] = tcrd_pkg::RANK_CH1;
            order[1] = b_ge_c ? tcrd_pkg::RANK_CH2 : tcrd_pkg::RANK_CH3;
            order[2] = b_ge_c ? tcrd_pkg::RANK_CH3 : tcrd_pkg::RANK_CH2;
        end
        else if (b_ge_a && b_ge_c)
        begin
            order[0] = tcrd_pkg::RANK_CH2;
            order[1] = a_ge_c ? tcrd_pkg::RANK_CH1 : tcrd_pkg::RANK_CH3;
            order[2] = a_ge_c ? tcrd_pkg::RANK_CH3 : tcrd_pkg::RANK_CH1;
        end
        else
        begin
            order[0] = tcrd_pkg::RANK_CH3;
            order[1] = a_ge_b ? tcrd_pkg::RANK_CH1 : tcrd_pkg::RANK_CH2;
            order[2] = a_ge_b ? tcrd_pkg::RANK_CH2 : tcrd_pkg::RANK_CH1;
        end
    end

    always_comb
    begin
        case (position)
            tcrd_pkg::POS_1: shown = order[1];
            tcrd_pkg::POS_2: shown = order[2];
            default:         shown = order[0];
        endcase
    end

    assign segment_pattern = tcrd_pkg::SEG_TABLE[{2'b00, shown}];

endmodule

`default_nettype wire

// ----- sv/three_channel_rank_display_top.sv -----
// Top level of the three-channel rank display: state, config port, result register.
//
//  channel | dir | fields                                              | handshake
//  --------+-----+-----------------------------------------------------+------------
//  in_ch   | in  | action, sample_value[9:0]                           | valid/ready
//  out_ch  | out | result_kind, next_channel[4:0], segment_pattern[6:0],| valid/ready
//          |     | digit_enable[2:0]                                   |
//  apb     | in  | psel, penable, pwrite, paddr[3:0], pwdata -> prdata | pready = 1
//
// One item per cycle while out_ch is not stalled: every item is worked out in a single
// combinational pass (3-way compare + segment lookup, or slot write + channel select)
// into the result register; out_ch.valid rises in the cycle after the accept.
// in_ch.ready is high while the result register is empty or being drained,
// so a stall on out_ch holds the pending result and blocks only new items.
// Reset zeroes samples, slot and scan digit; channel registers load 12, 10, 8.
`default_nettype none

module three_channel_rank_display_top #(
    parameter int SAMPLE_BITS = tcrd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    tcrd_in_if.sink                                  in_ch,
    tcrd_out_if.source                               out_ch,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tcrd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [tcrd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [tcrd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                     pready
);

    localparam int CB = tcrd_pkg::CHAN_BITS;

    // ---------------------------------------------------------------
    // Channel configuration registers
    // ---------------------------------------------------------------
    logic [CB-1:0] chan_reg [3];
    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic [CB-1:0] cfg_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg[0] <= tcrd_pkg::FIRST_CHAN_RST;
            chan_reg[1] <= tcrd_pkg::SECOND_CHAN_RST;
            chan_reg[2] <= tcrd_pkg::THIRD_CHAN_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tcrd_pkg::REG_FIRST_CHAN:  chan_reg[0] <= pwdata[CB-1:0];
                tcrd_pkg::REG_SECOND_CHAN: chan_reg[1] <= pwdata[CB-1:0];
                tcrd_pkg::REG_THIRD_CHAN:  chan_reg[2] <= pwdata[CB-1:0];
                default: ;  // no register there, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tcrd_pkg::REG_FIRST_CHAN:  cfg_rd = chan_reg[0];
            tcrd_pkg::REG_SECOND_CHAN: cfg_rd = chan_reg[1];
            tcrd_pkg::REG_THIRD_CHAN:  cfg_rd = chan_reg[2];
            default:                   cfg_rd = '0;
        endcase
    end

    assign prdata = {{(tcrd_pkg::APB_DATA_BITS - CB){1'b0}}, cfg_rd};

    // ---------------------------------------------------------------
    // Sample store and counters
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] samples_reg [3];
    logic [1:0]             sample_slot_reg;
    logic [1:0]             sample_slot_next;
    logic [1:0]             scan_digit_reg;
    logic [1:0]             scan_digit_next;
    logic [1:0]             slot;
    logic [1:0]             dig;
    logic                   accept;
    logic                   is_sample;
    logic [SAMPLE_BITS-1:0] sample_in;

    assign accept    = in_ch.valid && in_ch.ready;
    assign is_sample = (in_ch.action == tcrd_pkg::KIND_SAMPLE);
    // Zero-extend or truncate the converter word to the stored width
    assign sample_in = SAMPLE_BITS'(in_ch.sample_value);

    // Count value 3 is unreachable; treated as position 0
    assign slot = (sample_slot_reg == 2'd3) ? tcrd_pkg::POS_0 : sample_slot_reg;
    assign dig  = (scan_digit_reg == 2'd3) ? tcrd_pkg::POS_0 : scan_digit_reg;

    assign sample_slot_next = (slot == tcrd_pkg::POS_2) ? tcrd_pkg::POS_0 : slot + 2'd1;
    assign scan_digit_next  = (dig == tcrd_pkg::POS_2) ? tcrd_pkg::POS_0 : dig + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg[0]  <= '0;
            samples_reg[1]  <= '0;
            samples_reg[2]  <= '0;
            sample_slot_reg <= tcrd_pkg::POS_0;
            scan_digit_reg  <= tcrd_pkg::POS_0;
        end
        else if (accept)
        begin
            if (is_sample)
            begin
                case (slot)
                    tcrd_pkg::POS_1: samples_reg[1] <= sample_in;
                    tcrd_pkg::POS_2: samples_reg[2] <= sample_in;
                    default:         samples_reg[0] <= sample_in;
                endcase
                sample_slot_reg <= sample_slot_next;
            end
            else
            begin
                scan_digit_reg <= scan_digit_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result computation
    // ---------------------------------------------------------------
    logic [tcrd_pkg::SEG_BITS-1:0] rank_seg;
    logic [CB-1:0]                 next_chan;
    logic [tcrd_pkg::DIGITS-1:0]   dig_en;

    tcrd_rank #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rank (
        .samples         (samples_reg),
        .position        (dig),
        .segment_pattern (rank_seg)
    );

    always_comb
    begin
        case (sample_slot_next)
            tcrd_pkg::POS_1: next_chan = chan_reg[1];
            tcrd_pkg::POS_2: next_chan = chan_reg[2];
            default:         next_chan = chan_reg[0];
        endcase
    end

    assign dig_en = ~(tcrd_pkg::DIGIT_ONE_HOT << dig);

    // ---------------------------------------------------------------
    // Result register; refills in the same cycle it drains
    // ---------------------------------------------------------------
    logic                          out_valid_reg;
    logic                          kind_reg;
    logic [CB-1:0]                 next_channel_reg;
    logic [tcrd_pkg::SEG_BITS-1:0] segment_reg;
    logic [tcrd_pkg::DIGITS-1:0]   digit_en_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (is_sample)
            begin
                kind_reg         <= tcrd_pkg::KIND_SAMPLE;
                next_channel_reg <= next_chan;
                segment_reg      <= '0;
                digit_en_reg     <= tcrd_pkg::DIGITS_OFF;
            end
            else
            begin
                kind_reg         <= tcrd_pkg::KIND_DISPLAY;
                next_channel_reg <= '0;
                segment_reg      <= rank_seg;
                digit_en_reg     <= dig_en;
            end
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.result_kind     = kind_reg;
    assign out_ch.next_channel    = next_channel_reg;
    assign out_ch.segment_pattern = segment_reg;
    assign out_ch.digit_enable    = digit_en_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_slot_reg != 2'd3)
        else $error("sample slot reached 3");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_digit_reg != 2'd3)
        else $error("scan digit reached 3");

    a_display_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == tcrd_pkg::KIND_DISPLAY)
            |-> ($countones(digit_en_reg) == 2 && next_channel_reg == '0))
        else $error("display result without exactly one digit low");

    a_sample_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == tcrd_pkg::KIND_SAMPLE)
            |-> (digit_en_reg == tcrd_pkg::DIGITS_OFF && segment_reg == '0))
        else $error("sample result drives the display");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_sample) |=> (scan_digit_reg != $past(scan_digit_reg)
            && sample_slot_reg == $past(sample_slot_reg)))
        else $error("display tick did not advance only the scan digit");

endmodule

`default_nettype wire

// ----- tb/tcrd_rank_checker.sv -----
// Result checker for the three-channel rank display: tracks block state, compares each result item.
`timescale 1ns / 100ps

module tcrd_rank_checker #(
    parameter int SAMPLE_BITS = tcrd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tcrd_in_if                                      in_ch,
    tcrd_out_if                                     out_ch,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic                               pready,
    input  wire logic [tcrd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [tcrd_pkg::APB_DATA_BITS-1:0] pwdata,
    output int                                      fails,
    output int                                      owed
);
    import tcrd_pkg::*;

    typedef struct packed {
        kind_t                kind;
        logic [CHAN_BITS-1:0] next_chan;
        logic [SEG_BITS-1:0]  seg;
        logic [DIGITS-1:0]    digits;
    } answer_t;

    logic [SAMPLE_BITS-1:0] held [3];
    logic [1:0]             slot;
    logic [1:0]             scan;
    logic [CHAN_BITS-1:0]   chan_cfg [3];
    answer_t                owed_answers [$];

    // Channel number at a rank position; ties go to the lower channel
    function automatic rank_ch_t channel_at_rank(logic [1:0] pos);
        rank_ch_t               order [3];
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        logic [SAMPLE_BITS-1:0] c;
        a = held[0];
        b = held[1];
        c = held[2];
        if (a >= b && a >= c)
        begin
            order[0] = RANK_CH1;
            order[1] = (b >= c) ? RANK_CH2 : RANK_CH3;
            order[2] = (b >= c) ? RANK_CH3 : RANK_CH2;
        end
        else if (b >= a && b >= c)
        begin
            order[0] = RANK_CH2;
            order[1] = (a >= c) ? RANK_CH1 : RANK_CH3;
            order[2] = (a >= c) ? RANK_CH3 : RANK_CH1;
        end
        else
        begin
            order[0] = RANK_CH3;
            order[1] = (a >= b) ? RANK_CH1 : RANK_CH2;
            order[2] = (a >= b) ? RANK_CH2 : RANK_CH1;
        end
        return order[pos];
    endfunction

    // Applies one accepted item to the tracked state and returns its result item
    function automatic answer_t answer_for(logic act, logic [SAMPLE_IN_BITS-1:0] value);
        answer_t    ans;
        logic [1:0] pos;
        ans = '{kind: KIND_SAMPLE, next_chan: '0, seg: '0, digits: DIGITS_OFF};
        if (act == KIND_SAMPLE)
        begin
            pos = (slot > POS_2) ? POS_0 : slot;
            held[pos] = SAMPLE_BITS'(value);
            slot = (pos == POS_2) ? POS_0 : pos + 2'd1;
            ans.next_chan = chan_cfg[slot];
        end
        else
        begin
            pos = (scan > POS_2) ? POS_0 : scan;
            ans.kind = KIND_DISPLAY;
            ans.seg = SEG_TABLE[int'(channel_at_rank(pos))];
            ans.digits = DIGITS_OFF & ~(DIGIT_ONE_HOT << pos);
            scan = (pos == POS_2) ? POS_0 : pos + 2'd1;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            held[0] = '0;
            held[1] = '0;
            held[2] = '0;
            slot = POS_0;
            scan = POS_0;
            chan_cfg[0] = FIRST_CHAN_RST;
            chan_cfg[1] = SECOND_CHAN_RST;
            chan_cfg[2] = THIRD_CHAN_RST;
            owed_answers.delete();
            fails = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FIRST_CHAN:  chan_cfg[0] = pwdata[CHAN_BITS-1:0];
                    REG_SECOND_CHAN: chan_cfg[1] = pwdata[CHAN_BITS-1:0];
                    REG_THIRD_CHAN:  chan_cfg[2] = pwdata[CHAN_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                owed_answers.push_back(answer_for(in_ch.action, in_ch.sample_value));
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{kind: kind_t'(out_ch.result_kind), next_chan: out_ch.next_channel,
                        seg: out_ch.segment_pattern, digits: out_ch.digit_enable};
                if (owed_answers.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result kind %0d chan %0d seg %h digits %b",
                                 $realtime, got.kind, got.next_chan, got.seg, got.digits);
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (got.kind !== want.kind || got.next_chan !== want.next_chan ||
                        got.seg !== want.seg || got.digits !== want.digits)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display(
                                "%0t: mismatch kind/chan/seg/digits want %0d/%0d/%h/%b got %0d/%0d/%h/%b",
                                $realtime, want.kind, want.next_chan, want.seg,
                                want.digits, got.kind, got.next_chan, got.seg, got.digits);
                    end
                end
            end
        end
        owed = owed_answers.size();
    end

endmodule

// ----- tb/three_channel_rank_display_top_tb.sv -----
// Testbench top for the three-channel rank display: stimulus, flow control, verdict.
`timescale 1ns / 100ps

module three_channel_rank_display_top_tb;
    import tcrd_pkg::*;

    localparam int ITEMS_PER_PHASE = 155;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off to back up the block
    localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_GAP         = 17;
    // Address of the unused fourth register slot; writes there must change nothing
    localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = 4'hC;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       fails;
    int                       owed;
    int                       idle_cycles = 0;
    int                       items_sent  = 0;
    bit                       send_steady = 1'b0;
    bit                       take_steady = 1'b0;

    tcrd_in_if  in_ch ();
    tcrd_out_if out_ch ();

    three_channel_rank_display_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tracks the block's state from the channels and the config port
    tcrd_rank_checker rank_watch (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .fails   (fails),
        .owed    (owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle cycles before the next item; "steady" stretches run back to back
    function automatic int draw_gap(bit steady);
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offers one item after a random gap and waits for the handshake.
    // Valid stays high across back-to-back items, so it gets one assignment per step.
    task automatic send_item(kind_t act, logic [SAMPLE_IN_BITS-1:0] value);
        int gap;
        gap = draw_gap(send_steady);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid        <= 1'b0;
            in_ch.action       <= 1'($urandom);
            in_ch.sample_value <= SAMPLE_IN_BITS'($urandom);
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.sample_value <= value;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready))
            @(posedge clk);
        items_sent++;
        if (items_sent % 40 == 0)
            send_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Loads all three slots, then scans every digit so each rank position shows
    task automatic fill_and_scan(logic [SAMPLE_IN_BITS-1:0] s1, logic [SAMPLE_IN_BITS-1:0] s2,
                                 logic [SAMPLE_IN_BITS-1:0] s3);
        send_item(KIND_SAMPLE, s1);
        send_item(KIND_SAMPLE, s2);
        send_item(KIND_SAMPLE, s3);
        repeat (DIGITS) send_item(KIND_DISPLAY, '0);
    endtask

    task automatic write_reg(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper data bits carry junk; only the low five bits may land in the register
    task automatic set_channels(logic [CHAN_BITS-1:0] c1, logic [CHAN_BITS-1:0] c2,
                                logic [CHAN_BITS-1:0] c3);
        write_reg({REG_FIRST_CHAN, 2'b00}, {$urandom} & ~32'h1F | c1);
        write_reg({REG_SECOND_CHAN, 2'b00}, {$urandom} & ~32'h1F | c2);
        write_reg({REG_THIRD_CHAN, 2'b00}, {$urandom} & ~32'h1F | c3);
    endtask

    // Random samples and ticks. Samples lean toward the extremes and toward a
    // tiny range, so equal values (the tie rules) turn up often.
    task automatic run_phase(int count);
        logic [SAMPLE_IN_BITS-1:0] value;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: value = SAMPLE_IN_BITS'($urandom_range(0, 3));
                1: value = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: value = SAMPLE_IN_BITS'($urandom);
            endcase
            send_item(kind_t'($urandom_range(0, 1)), value);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;
        // Every item gives exactly one result, so an empty queue means the block is idle
        wait (owed == 0);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = KIND_SAMPLE;
        in_ch.sample_value = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: scan with all samples zero (full three-way tie), then four sets with each
        // channel winning at least once, the runner-up order flipped, and ties at top and bottom
        repeat (DIGITS) send_item(KIND_DISPLAY, '0);
        fill_and_scan(10'd1023, 10'd0, 10'd1);
        fill_and_scan(10'd0, 10'd1023, 10'd1023);
        fill_and_scan(10'd512, 10'd512, 10'd1023);
        fill_and_scan(10'd600, 10'd900, 10'd600);

        // Reset channel numbers first, then both extremes and two random sets
        run_phase(ITEMS_PER_PHASE);
        set_channels('0, '0, '0);
        write_reg(SPARE_ADDR, '1);
        run_phase(ITEMS_PER_PHASE);
        set_channels('1, '1, '1);
        run_phase(ITEMS_PER_PHASE);
        set_channels(CHAN_BITS'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom));
        run_phase(ITEMS_PER_PHASE);
        set_channels(CHAN_BITS'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom));
        write_reg(SPARE_ADDR, '0);
        run_phase(ITEMS_PER_PHASE);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("three_channel_rank_display_top_tb OK");
        else
            $display("three_channel_rank_display_top_tb NOT OK");
        $finish;
    end

    // Result side: random ready gaps, with a long hold-off now and then while the
    // sender keeps offering, so the result register fills and input ready drops
    initial
    begin : result_taker
        int gap;
        int taken;
        out_ch.ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = (taken % 250 == 120) ? HOLD_CYCLES : draw_gap(take_steady);
            repeat (gap)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready))
                @(posedge clk);
            taken++;
            if (taken % 32 == 0)
                take_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: any handshake on either channel or the config port restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("three_channel_rank_display_top_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- three_channel_rank_display_top.f -----
sv/tcrd_pkg.sv
sv/tcrd_in_if.sv
sv/tcrd_out_if.sv
sv/tcrd_rank.sv
sv/three_channel_rank_display_top.sv
tb/tcrd_rank_checker.sv
tb/three_channel_rank_display_top_tb.sv
